>>> rtl/mfac_pkg.sv
// shared types, constants and helpers for the motor fault alarm classifier
`default_nettype none
package mfac_pkg;

    localparam int MOTORS = 8;
    localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    localparam int SLOT_W = 3;
    localparam int TEMP_W = 12;
    localparam int WORD_W = 16;
    localparam int POS_W  = 17;
    localparam int CODE_W = 4;
    localparam int CNT_W  = 2;
    localparam int CIDX_W = 3;

    localparam logic [WORD_W-1:0] HOME_WINDOW_S = 16'd10;
    localparam int HOME_LOW     = 200;
    localparam int HOME_SLACK   = 50;
    localparam int TRAVEL_SLACK = 200;
    localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;

    localparam logic signed [TEMP_W-1:0] TEMP_LIMIT_RST = 12'sd800;
    localparam logic [WORD_W-1:0] VOLT_LOW_RST     = 16'd4500;
    localparam logic [WORD_W-1:0] VOLT_HIGH_RST    = 16'd5000;
    localparam logic [WORD_W-1:0] CURRENT_LIM_RST  = 16'd12500;
    localparam logic [WORD_W-1:0] BATT_LOW_RST     = 16'd290;
    localparam logic [WORD_W-1:0] BATT_HIGH_RST    = 16'd320;
    localparam logic [WORD_W-1:0] MAX_TRAVEL_RST   = 16'd9000;
    localparam logic [CNT_W-1:0]  VOLT_DEBOUNCE_RST = 2'd3;

    typedef enum logic [CODE_W-1:0] {
        ALM_OK         = 4'd0,
        ALM_TEMP       = 4'd1,
        ALM_STATUS     = 4'd2,
        ALM_VOLT       = 4'd3,
        ALM_CURRENT    = 4'd4,
        ALM_BATT_BAND  = 4'd5,
        ALM_BATT_LOW   = 4'd6,
        ALM_NOT_HOMED  = 4'd7,
        ALM_OVERTRAVEL = 4'd8,
        ALM_DISCONNECT = 4'd9,
        ALM_HOMING     = 4'd10
    } t_alarm;

    typedef enum logic [CIDX_W-1:0] {
        CFG_TEMP_LIMIT    = 3'd0,
        CFG_VOLT_LOW      = 3'd1,
        CFG_VOLT_HIGH     = 3'd2,
        CFG_CURRENT_LIMIT = 3'd3,
        CFG_BATT_LOW      = 3'd4,
        CFG_BATT_HIGH     = 3'd5,
        CFG_MAX_TRAVEL    = 3'd6,
        CFG_VOLT_DEBOUNCE = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_limit;
        logic [WORD_W-1:0]        volt_low;
        logic [WORD_W-1:0]        volt_high;
        logic [WORD_W-1:0]        current_limit;
        logic [WORD_W-1:0]        battery_low;
        logic [WORD_W-1:0]        battery_high;
        logic [WORD_W-1:0]        max_travel;
        logic [CNT_W-1:0]         voltage_debounce;
    } t_cfg;

    typedef struct packed {
        logic [SLOT_W-1:0]        motor_slot;
        logic                     disconnected;
        logic signed [TEMP_W-1:0] temperature;
        logic                     status_error;
        logic [WORD_W-1:0]        voltage;
        logic [WORD_W-1:0]        current;
        logic [WORD_W-1:0]        battery_raw;
        logic signed [POS_W-1:0]  position;
        logic [WORD_W-1:0]        run_seconds;
    } t_sample;

    // per-motor state as read and as written back
    typedef struct packed {
        logic [CNT_W-1:0] volt_cnt;
        logic             mark;
    } t_motor_state;

    function automatic logic [MIDX_W-1:0] slot_index(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W+MIDX_W-1:0] wide;
        wide = {{MIDX_W{1'b0}}, slot};
        return wide[MIDX_W-1:0];
    endfunction

    function automatic logic slot_in_range(input logic [SLOT_W-1:0] slot);
        return (32'(slot) < 32'(MOTORS));
    endfunction

endpackage
`default_nettype wire

>>> rtl/motor_fault_alarm_classifier_top.sv
// Motor fault alarm classifier, top level.
// One request on the input channel carries one motor sample; each request
// gives exactly one result: the motor slot, an alarm code and the plate
// angle passed through. Checks override in a fixed order, with disconnect
// ending the checks, and the homing window decided by run_seconds.
// The sample is captured in an input register; the classification and the
// per-motor state update (voltage debounce count, not-homed mark) are
// combinational from it into the result register. One request is taken
// every cycle while the receiver does not stall.
// Per-motor state is read and written in the same cycle, so back-to-back
// samples of one motor need no forwarding.
// When the receiver stalls, the result holds and the input register keeps
// one more sample; input ready drops once both are full.
// The configuration channel is always ready; write it only when idle.
// Synchronous active-low reset clears the valid flags and the per-motor
// state, and loads the default thresholds.
`default_nettype none
module motor_fault_alarm_classifier_top (
    input  var logic                          i_clk,
    input  var logic                          i_rst_n,
    input  var logic                          i_cfg_valid,
    output logic                              o_cfg_ready,
    input  var logic [mfac_pkg::CIDX_W-1:0]   i_cfg_index,
    input  var logic [mfac_pkg::WORD_W-1:0]   i_cfg_data,
    input  var logic                          i_in_valid,
    output logic                              o_in_ready,
    input  var logic [mfac_pkg::SLOT_W-1:0]   i_motor_slot,
    input  var logic                          i_disconnected,
    input  var logic signed [mfac_pkg::TEMP_W-1:0] i_temperature,
    input  var logic                          i_status_error,
    input  var logic [mfac_pkg::WORD_W-1:0]   i_voltage,
    input  var logic [mfac_pkg::WORD_W-1:0]   i_current,
    input  var logic [mfac_pkg::WORD_W-1:0]   i_battery_raw,
    input  var logic signed [mfac_pkg::POS_W-1:0]  i_position,
    input  var logic [mfac_pkg::WORD_W-1:0]   i_run_seconds,
    output logic                              o_out_valid,
    input  var logic                          i_out_ready,
    output logic [mfac_pkg::SLOT_W-1:0]       o_motor_slot_out,
    output logic [mfac_pkg::CODE_W-1:0]       o_alarm_code,
    output logic signed [mfac_pkg::POS_W-1:0] o_plate_angle
);
    import mfac_pkg::*;

    t_cfg         r_cfg;
    logic         r_in_valid;
    t_sample      r_in;
    logic         r_out_valid;
    logic [SLOT_W-1:0]       r_out_slot;
    t_alarm                  r_out_code;
    logic signed [POS_W-1:0] r_out_pos;
    logic [CNT_W-1:0] r_volt_cnt [MOTORS];
    logic             r_mark     [MOTORS];

    logic         advance;
    logic         fire;
    logic         slot_ok;
    logic [MIDX_W-1:0] idx;
    t_motor_state cur_state;
    t_motor_state n_state;
    t_alarm       n_code;

    assign o_cfg_ready = 1'b1;
    assign advance     = !r_out_valid || i_out_ready;
    assign fire        = r_in_valid && advance;
    assign o_in_ready  = !r_in_valid || advance;

    assign slot_ok = slot_in_range(r_in.motor_slot);
    assign idx     = slot_index(r_in.motor_slot);

    // slots beyond the motor count read as zero state
    always_comb begin
        cur_state = '0;
        if (slot_ok) begin
            cur_state.volt_cnt = r_volt_cnt[idx];
            cur_state.mark     = r_mark[idx];
        end
    end

    mfac_classify u_classify (
        .i_sample (r_in),
        .i_cfg    (r_cfg),
        .i_state  (cur_state),
        .o_alarm  (n_code),
        .o_state  (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_limit       <= TEMP_LIMIT_RST;
            r_cfg.volt_low         <= VOLT_LOW_RST;
            r_cfg.volt_high        <= VOLT_HIGH_RST;
            r_cfg.current_limit    <= CURRENT_LIM_RST;
            r_cfg.battery_low      <= BATT_LOW_RST;
            r_cfg.battery_high     <= BATT_HIGH_RST;
            r_cfg.max_travel       <= MAX_TRAVEL_RST;
            r_cfg.voltage_debounce <= VOLT_DEBOUNCE_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_TEMP_LIMIT:    r_cfg.temp_limit <= $signed(i_cfg_data[TEMP_W-1:0]);
                CFG_VOLT_LOW:      r_cfg.volt_low <= i_cfg_data;
                CFG_VOLT_HIGH:     r_cfg.volt_high <= i_cfg_data;
                CFG_CURRENT_LIMIT: r_cfg.current_limit <= i_cfg_data;
                CFG_BATT_LOW:      r_cfg.battery_low <= i_cfg_data;
                CFG_BATT_HIGH:     r_cfg.battery_high <= i_cfg_data;
                CFG_MAX_TRAVEL:    r_cfg.max_travel <= i_cfg_data;
                CFG_VOLT_DEBOUNCE: r_cfg.voltage_debounce <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.motor_slot   <= i_motor_slot;
            r_in.disconnected <= i_disconnected;
            r_in.temperature  <= i_temperature;
            r_in.status_error <= i_status_error;
            r_in.voltage      <= i_voltage;
            r_in.current      <= i_current;
            r_in.battery_raw  <= i_battery_raw;
            r_in.position     <= i_position;
            r_in.run_seconds  <= i_run_seconds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_slot <= r_in.motor_slot;
            r_out_code <= n_code;
            r_out_pos  <= r_in.position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MOTORS; m++) begin
                r_volt_cnt[m] <= '0;
                r_mark[m]     <= 1'b0;
            end
        end else if (fire && slot_ok) begin
            r_volt_cnt[idx] <= n_state.volt_cnt;
            r_mark[idx]     <= n_state.mark;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_motor_slot_out = r_out_slot;
    assign o_alarm_code     = r_out_code;
    assign o_plate_angle    = r_out_pos;

endmodule
`default_nettype wire

>>> rtl/mfac_classify.sv
// alarm priority logic and per-motor state update for one sample
`default_nettype none
module mfac_classify (
    input  var mfac_pkg::t_sample      i_sample,
    input  var mfac_pkg::t_cfg         i_cfg,
    input  var mfac_pkg::t_motor_state i_state,
    output mfac_pkg::t_alarm           o_alarm,
    output mfac_pkg::t_motor_state     o_state
);
    import mfac_pkg::*;

    logic                   volt_bad;
    logic [CNT_W-1:0]       cnt_inc;
    logic signed [POS_W:0]  pos_x;
    logic signed [POS_W:0]  home_high;
    logic signed [POS_W:0]  travel_high;
    logic                   away_from_home;
    logic                   over_travel;

    assign volt_bad = (i_sample.voltage < i_cfg.volt_low) ||
                      (i_sample.voltage > i_cfg.volt_high);
    assign cnt_inc  = (i_state.volt_cnt < CNT_MAX) ? i_state.volt_cnt + 2'd1
                                                   : i_state.volt_cnt;

    // one extra bit so max_travel plus slack compares signed without overflow
    assign pos_x       = (POS_W+1)'(i_sample.position);
    assign home_high   = $signed({2'b00, i_cfg.max_travel}) + (POS_W+1)'(HOME_SLACK);
    assign travel_high = $signed({2'b00, i_cfg.max_travel}) + (POS_W+1)'(TRAVEL_SLACK);
    assign away_from_home = (pos_x > (POS_W+1)'(HOME_LOW)) && (pos_x < home_high);
    assign over_travel    = (pos_x < -(POS_W+1)'(TRAVEL_SLACK)) || (pos_x > travel_high);

    always_comb begin
        o_alarm = ALM_OK;
        o_state = i_state;
        if (i_sample.disconnected) begin
            o_alarm = ALM_DISCONNECT;
        end else begin
            if (i_sample.temperature > i_cfg.temp_limit) begin
                o_alarm = ALM_TEMP;
            end
            if (i_sample.status_error) begin
                o_alarm = ALM_STATUS;
            end
            if (volt_bad) begin
                o_state.volt_cnt = cnt_inc;
                if (cnt_inc >= i_cfg.voltage_debounce) begin
                    o_alarm = ALM_VOLT;
                end
            end else begin
                o_state.volt_cnt = '0;
            end
            if (i_sample.current > i_cfg.current_limit) begin
                o_alarm = ALM_CURRENT;
            end
            if ((i_sample.battery_raw >= i_cfg.battery_low) &&
                (i_sample.battery_raw <= i_cfg.battery_high)) begin
                o_alarm = ALM_BATT_BAND;
            end else if (i_sample.battery_raw < i_cfg.battery_low) begin
                o_alarm = ALM_BATT_LOW;
            end
            if (i_sample.run_seconds < HOME_WINDOW_S) begin
                o_state.mark = away_from_home;
                if (away_from_home) begin
                    o_alarm = ALM_HOMING;
                end
            end else if (i_state.mark) begin
                o_alarm = ALM_NOT_HOMED;
            end else if (over_travel) begin
                o_alarm = ALM_OVERTRAVEL;
            end
        end
    end

endmodule
`default_nettype wire
